// File: hw/rtl/i2cm_pkg.sv
// shared types and constants of the i2c master byte engine
package i2cm_pkg;

  localparam int unsigned CmdWidth   = 3;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned HalfWidth  = 16;
  localparam int unsigned TmoWidth   = 8;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [HalfWidth-1:0] HALF_PERIOD_RESET = 16'd50;
  localparam logic [TmoWidth-1:0]  ACK_TIMEOUT_RESET = 8'd250;

  // raw command codes on the input channel
  localparam logic [CmdWidth-1:0] CMD_NONE  = 3'd0;
  localparam logic [CmdWidth-1:0] CMD_START = 3'd1;
  localparam logic [CmdWidth-1:0] CMD_WRITE = 3'd2;
  localparam logic [CmdWidth-1:0] CMD_READ  = 3'd3;
  localparam logic [CmdWidth-1:0] CMD_STOP  = 3'd4;

  // configuration register indexes
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_WRITE,
    OP_READ,
    OP_STOP
  } op_e;

  // classified tick handed from front to back
  typedef struct packed {
    op_e                  op;
    logic [ByteWidth-1:0] tx_byte;
    logic                 send_ack;
    logic                 sda_in;
  } tick_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 busy_res;
    logic                 done_res;
    logic [ByteWidth-1:0] rx_byte;
    logic                 ack_error;
  } result_t;

endpackage

// File: hw/rtl/i2cm_if.sv
// channel interfaces of the i2c master byte engine
interface i2cm_in_if;
  logic                             valid;
  logic                             ready;
  logic [i2cm_pkg::CmdWidth-1:0]    command;
  logic [i2cm_pkg::ByteWidth-1:0]   tx_byte;
  logic                             send_ack;
  logic                             sda_in;

  modport source (output valid, command, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, command, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic                             valid;
  logic                             ready;
  logic                             scl_level;
  logic                             sda_level;
  logic                             busy_res;
  logic                             done_res;
  logic [i2cm_pkg::ByteWidth-1:0]   rx_byte;
  logic                             ack_error;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                  ack_error, input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                  ack_error, output ready);
endinterface

// File: hw/rtl/i2c_master_byte_engine.sv
// top level of the i2c master byte engine
//
//   channel   dir  beat                                      handshake
//   in_if     in   command, tx_byte, send_ack, sda_in        valid/ready
//   out_if    out  scl_level, sda_level, busy_res, done_res,  valid/ready
//                  rx_byte, ack_error
//   cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i           write enable only
//
// one beat in gives one beat out; a beat is taken every cycle while the queue is
// not full, and its result appears in the cycle after the sequencer steps on it;
// it passes the queue and then the output register. the sequencer state update
// is the only per-tick loop. reset returns both lines released, the sequencer
// idle and the registers to half period 50 and ack timeout 250; a stalled
// output holds the sequencer, and the queue absorbs input beats until it fills.
module i2c_master_byte_engine #(
  parameter int unsigned QueueDepth = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [i2cm_pkg::CfgWidth-1:0]    cfg_data_i,
  i2cm_in_if.sink                          in_if,
  i2cm_out_if.source                       out_if
);

  logic [i2cm_pkg::HalfWidth-1:0] half_q;
  logic [i2cm_pkg::TmoWidth-1:0]  tmo_q;
  logic                           push, full, pop, q_valid;
  i2cm_pkg::tick_t                tick_in, tick_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= i2cm_pkg::HALF_PERIOD_RESET;
      tmo_q  <= i2cm_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        i2cm_pkg::CFG_HALF_PERIOD: half_q <= cfg_data_i;
        i2cm_pkg::CFG_ACK_TIMEOUT: tmo_q  <= cfg_data_i[i2cm_pkg::TmoWidth-1:0];
        default: ;
      endcase
    end
  end

  i2cm_front u_front (
    .in_if    (in_if),
    .q_full_i (full),
    .push_o   (push),
    .tick_o   (tick_in)
  );

  i2cm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tick_i  (tick_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .tick_o  (tick_out)
  );

  i2cm_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .half_period_i (half_q),
    .ack_timeout_i (tmo_q),
    .q_valid_i     (q_valid),
    .tick_i        (tick_out),
    .pop_o         (pop),
    .out_if        (out_if)
  );

endmodule

// File: hw/rtl/i2cm_front.sv
// front end: takes input beats and classifies the command
module i2cm_front (
  i2cm_in_if.sink                 in_if,
  input  logic                    q_full_i,
  output logic                    push_o,
  output i2cm_pkg::tick_t         tick_o
);

  i2cm_pkg::op_e op;

  always_comb begin
    case (in_if.command)
      i2cm_pkg::CMD_START: op = i2cm_pkg::OP_START;
      i2cm_pkg::CMD_WRITE: op = i2cm_pkg::OP_WRITE;
      i2cm_pkg::CMD_READ:  op = i2cm_pkg::OP_READ;
      i2cm_pkg::CMD_STOP:  op = i2cm_pkg::OP_STOP;
      default:             op = i2cm_pkg::OP_NONE;
    endcase
  end

  assign in_if.ready      = !q_full_i;
  assign push_o           = in_if.valid && !q_full_i;
  assign tick_o.op        = op;
  assign tick_o.tx_byte   = in_if.tx_byte;
  assign tick_o.send_ack  = in_if.send_ack;
  assign tick_o.sda_in    = in_if.sda_in;

endmodule

// File: hw/rtl/i2cm_queue.sv
// short queue of classified ticks between front and back
module i2cm_queue #(
  parameter int unsigned Depth = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  i2cm_pkg::tick_t  tick_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output i2cm_pkg::tick_t  tick_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  i2cm_pkg::tick_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign tick_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= tick_i;
    end
  end

endmodule

// File: hw/rtl/i2cm_engine.sv
// back end: i2c bit sequencer stepped once per tick, with output register
module i2cm_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [i2cm_pkg::HalfWidth-1:0]      half_period_i,
  input  logic [i2cm_pkg::TmoWidth-1:0]       ack_timeout_i,
  input  logic                                q_valid_i,
  input  i2cm_pkg::tick_t                     tick_i,
  output logic                                pop_o,
  i2cm_out_if.source                          out_if
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_REL, PH_ST_SCL, PH_ST_SDA, PH_W_LOW, PH_W_HIGH, PH_WA_LOW,
    PH_WA_WAIT, PH_R_LOW, PH_R_HIGH, PH_RA_LOW, PH_RA_HIGH, PH_SP_LOW,
    PH_SP_SCL, PH_SP_SDA
  } phase_e;

  phase_e                            phase_q, phase_d;
  logic [3:0]                        bit_q, bit_d;
  logic [i2cm_pkg::ByteWidth-1:0]    shift_q, shift_d;
  logic [i2cm_pkg::HalfWidth-1:0]    dly_q, dly_d, dly_load;
  logic [i2cm_pkg::TmoWidth-1:0]     wait_q, wait_d;
  logic [i2cm_pkg::ByteWidth-1:0]    rx_q, rx_d;
  logic                              scl_q, scl_d, sda_q, sda_d;
  logic                              ackf_q, ackf_d, choice_q, choice_d;
  logic                              done;
  logic                              expired;
  logic                              out_valid_q;
  i2cm_pkg::result_t                 res_q, res_d;

  // a tick is taken whenever the output register is free or drains this cycle
  assign pop_o    = q_valid_i && (!out_valid_q || out_if.ready);
  assign dly_load = (half_period_i == '0) ? i2cm_pkg::HalfWidth'(1) : half_period_i;
  assign expired  = (dly_q <= i2cm_pkg::HalfWidth'(1));

  always_comb begin
    phase_d  = phase_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    dly_d    = dly_q;
    wait_d   = wait_q;
    rx_d     = rx_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ackf_d   = ackf_q;
    choice_d = choice_q;
    done     = 1'b0;

    // timed phases count down until their last tick
    if (phase_q != PH_IDLE && phase_q != PH_WA_WAIT && !expired) begin
      dly_d = dly_q - 1'b1;
    end

    case (phase_q)
      PH_IDLE: begin
        case (tick_i.op)
          i2cm_pkg::OP_START: begin
            sda_d = 1'b1; phase_d = PH_ST_REL; dly_d = dly_load;
          end
          i2cm_pkg::OP_WRITE: begin
            ackf_d = 1'b0; shift_d = tick_i.tx_byte; bit_d = '0;
            scl_d = 1'b0; sda_d = tick_i.tx_byte[7];
            phase_d = PH_W_LOW; dly_d = dly_load;
          end
          i2cm_pkg::OP_READ: begin
            choice_d = tick_i.send_ack; shift_d = '0; bit_d = '0;
            scl_d = 1'b0; sda_d = 1'b1; phase_d = PH_R_LOW; dly_d = dly_load;
          end
          i2cm_pkg::OP_STOP: begin
            scl_d = 1'b0; sda_d = 1'b0; phase_d = PH_SP_LOW; dly_d = dly_load;
          end
          default: ;
        endcase
      end
      PH_ST_REL: if (expired) begin
        scl_d = 1'b1; phase_d = PH_ST_SCL; dly_d = dly_load;
      end
      PH_ST_SCL: if (expired) begin
        sda_d = 1'b0; phase_d = PH_ST_SDA; dly_d = dly_load;
      end
      PH_ST_SDA: if (expired) begin
        scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
      end
      PH_W_LOW: if (expired) begin
        scl_d = 1'b1; phase_d = PH_W_HIGH; dly_d = dly_load;
      end
      PH_W_HIGH: if (expired) begin
        scl_d = 1'b0;
        bit_d = bit_q + 1'b1;
        dly_d = dly_load;
        if (bit_d >= 4'd8) begin
          sda_d = 1'b1; phase_d = PH_WA_LOW;
        end else begin
          shift_d = {shift_q[6:0], 1'b0};
          sda_d   = shift_q[6];
          phase_d = PH_W_LOW;
        end
      end
      PH_WA_LOW: if (expired) begin
        scl_d = 1'b1; wait_d = '0; phase_d = PH_WA_WAIT;
      end
      PH_WA_WAIT: begin
        if (!tick_i.sda_in) begin
          scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
        end else begin
          wait_d = wait_q + 1'b1;
          // no ack in time: flag it and stop on our own
          if (wait_d >= ack_timeout_i) begin
            ackf_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
            phase_d = PH_SP_LOW; dly_d = dly_load;
          end
        end
      end
      PH_R_LOW: if (expired) begin
        scl_d = 1'b1; phase_d = PH_R_HIGH; dly_d = dly_load;
      end
      PH_R_HIGH: if (expired) begin
        shift_d = {shift_q[6:0], tick_i.sda_in};
        scl_d   = 1'b0;
        bit_d   = bit_q + 1'b1;
        dly_d   = dly_load;
        if (bit_d >= 4'd8) begin
          rx_d = shift_d; sda_d = !choice_q; phase_d = PH_RA_LOW;
        end else begin
          phase_d = PH_R_LOW;
        end
      end
      PH_RA_LOW: if (expired) begin
        scl_d = 1'b1; phase_d = PH_RA_HIGH; dly_d = dly_load;
      end
      PH_RA_HIGH: if (expired) begin
        scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
      end
      PH_SP_LOW: if (expired) begin
        scl_d = 1'b1; phase_d = PH_SP_SCL; dly_d = dly_load;
      end
      PH_SP_SCL: if (expired) begin
        sda_d = 1'b1; phase_d = PH_SP_SDA; dly_d = dly_load;
      end
      PH_SP_SDA: if (expired) begin
        phase_d = PH_IDLE; done = 1'b1;
      end
      default: phase_d = PH_IDLE;
    endcase

    res_d.scl_level = scl_d;
    res_d.sda_level = sda_d;
    res_d.busy_res  = (phase_d != PH_IDLE);
    res_d.done_res  = done;
    res_d.rx_byte   = rx_d;
    res_d.ack_error = ackf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_q       <= '0;
      shift_q     <= '0;
      dly_q       <= '0;
      wait_q      <= '0;
      rx_q        <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ackf_q      <= 1'b0;
      choice_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q  <= phase_d;
        bit_q    <= bit_d;
        shift_q  <= shift_d;
        dly_q    <= dly_d;
        wait_q   <= wait_d;
        rx_q     <= rx_d;
        scl_q    <= scl_d;
        sda_q    <= sda_d;
        ackf_q   <= ackf_d;
        choice_q <= choice_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.scl_level = res_q.scl_level;
  assign out_if.sda_level = res_q.sda_level;
  assign out_if.busy_res  = res_q.busy_res;
  assign out_if.done_res  = res_q.done_res;
  assign out_if.rx_byte   = res_q.rx_byte;
  assign out_if.ack_error = res_q.ack_error;

endmodule

// File: verif/tb_top.sv
// testbench for the i2c master byte engine: per-tick predictor and scoreboard on the result channel
`timescale 1ns / 100ps

module tb_top;

  // sequencer phases of the predictor
  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_START_REL,
    SEQ_START_SCL,
    SEQ_START_SDA,
    SEQ_WR_LOW,
    SEQ_WR_HIGH,
    SEQ_WACK_LOW,
    SEQ_WACK_POLL,
    SEQ_RD_LOW,
    SEQ_RD_HIGH,
    SEQ_RACK_LOW,
    SEQ_RACK_HIGH,
    SEQ_STOP_LOW,
    SEQ_STOP_SCL,
    SEQ_STOP_SDA
  } seq_e;

  localparam int unsigned NO_ACK = 1000;
  localparam int unsigned SDA_LOW = 0;
  localparam int unsigned SDA_HIGH = 1;
  localparam int unsigned SDA_RANDOM = 2;

  logic                          clk;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic                          cfg_idx_i;
  logic [i2cm_pkg::CfgWidth-1:0] cfg_data_i;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();

  i2c_master_byte_engine uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // predictor state
  logic [i2cm_pkg::HalfWidth-1:0] half_cfg;
  logic [i2cm_pkg::TmoWidth-1:0]  tmo_cfg;
  seq_e                           m_seq;
  logic [3:0]                     m_bit;
  logic [7:0]                     m_shift;
  logic [15:0]                    m_delay;
  logic [7:0]                     m_poll;
  logic [7:0]                     m_rx;
  logic                           m_scl;
  logic                           m_sda;
  logic                           m_nack;
  logic                           m_ack_choice;

  i2cm_pkg::result_t pending_bus_q[$];
  bit                gaps_on;
  int unsigned       n_ticks;
  int unsigned       n_cmds;
  int unsigned       n_checked;
  int unsigned       n_mismatch;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #16_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void load_delay(seq_e nxt);
    m_seq = nxt;
    m_delay = (half_cfg == '0) ? 16'd1 : half_cfg;
  endfunction

  function automatic bit delay_over();
    if (m_delay > 16'd1) begin
      m_delay = m_delay - 16'd1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void start_stop();
    m_scl = 1'b0;
    m_sda = 1'b0;
    load_delay(SEQ_STOP_LOW);
  endfunction

  // one tick of the engine; returns the bus levels and status after the tick
  function automatic i2cm_pkg::result_t advance_engine(logic [2:0] cmd, logic [7:0] tx,
                                                       logic ack_sel, logic sda);
    i2cm_pkg::result_t r;
    logic              done;
    done = 1'b0;
    case (m_seq)
      SEQ_IDLE: begin
        if (cmd == i2cm_pkg::CMD_START) begin
          m_sda = 1'b1;
          load_delay(SEQ_START_REL);
        end else if (cmd == i2cm_pkg::CMD_WRITE) begin
          m_nack = 1'b0;
          m_shift = tx;
          m_bit = '0;
          m_scl = 1'b0;
          m_sda = tx[7];
          load_delay(SEQ_WR_LOW);
        end else if (cmd == i2cm_pkg::CMD_READ) begin
          m_ack_choice = ack_sel;
          m_shift = '0;
          m_bit = '0;
          m_scl = 1'b0;
          m_sda = 1'b1;
          load_delay(SEQ_RD_LOW);
        end else if (cmd == i2cm_pkg::CMD_STOP) begin
          start_stop();
        end
      end
      SEQ_START_REL: if (delay_over()) begin
        m_scl = 1'b1;
        load_delay(SEQ_START_SCL);
      end
      SEQ_START_SCL: if (delay_over()) begin
        m_sda = 1'b0;
        load_delay(SEQ_START_SDA);
      end
      SEQ_START_SDA: if (delay_over()) begin
        m_scl = 1'b0;
        m_seq = SEQ_IDLE;
        done = 1'b1;
      end
      SEQ_WR_LOW: if (delay_over()) begin
        m_scl = 1'b1;
        load_delay(SEQ_WR_HIGH);
      end
      SEQ_WR_HIGH: if (delay_over()) begin
        m_scl = 1'b0;
        m_bit = m_bit + 4'd1;
        if (m_bit >= 4'd8) begin
          m_sda = 1'b1;
          load_delay(SEQ_WACK_LOW);
        end else begin
          m_shift = m_shift << 1;
          m_sda = m_shift[7];
          load_delay(SEQ_WR_LOW);
        end
      end
      SEQ_WACK_LOW: if (delay_over()) begin
        m_scl = 1'b1;
        m_poll = '0;
        m_seq = SEQ_WACK_POLL;
      end
      SEQ_WACK_POLL: begin
        if (!sda) begin
          m_scl = 1'b0;
          m_seq = SEQ_IDLE;
          done = 1'b1;
        end else begin
          m_poll = m_poll + 8'd1;
          // no ack in time: flag it and close the transfer
          if (m_poll >= tmo_cfg) begin
            m_nack = 1'b1;
            start_stop();
          end
        end
      end
      SEQ_RD_LOW: if (delay_over()) begin
        m_scl = 1'b1;
        load_delay(SEQ_RD_HIGH);
      end
      SEQ_RD_HIGH: if (delay_over()) begin
        m_shift = {m_shift[6:0], sda};
        m_scl = 1'b0;
        m_bit = m_bit + 4'd1;
        if (m_bit >= 4'd8) begin
          m_rx = m_shift;
          m_sda = ~m_ack_choice;
          load_delay(SEQ_RACK_LOW);
        end else begin
          load_delay(SEQ_RD_LOW);
        end
      end
      SEQ_RACK_LOW: if (delay_over()) begin
        m_scl = 1'b1;
        load_delay(SEQ_RACK_HIGH);
      end
      SEQ_RACK_HIGH: if (delay_over()) begin
        m_scl = 1'b0;
        m_seq = SEQ_IDLE;
        done = 1'b1;
      end
      SEQ_STOP_LOW: if (delay_over()) begin
        m_scl = 1'b1;
        load_delay(SEQ_STOP_SCL);
      end
      SEQ_STOP_SCL: if (delay_over()) begin
        m_sda = 1'b1;
        load_delay(SEQ_STOP_SDA);
      end
      SEQ_STOP_SDA: if (delay_over()) begin
        m_seq = SEQ_IDLE;
        done = 1'b1;
      end
      default: m_seq = SEQ_IDLE;
    endcase
    r.scl_level = m_scl;
    r.sda_level = m_sda;
    r.busy_res  = (m_seq != SEQ_IDLE);
    r.done_res  = done;
    r.rx_byte   = m_rx;
    r.ack_error = m_nack;
    return r;
  endfunction

  task automatic send_tick(logic [2:0] cmd, logic [7:0] tx, logic ack_sel, logic sda);
    i2cm_pkg::result_t beat;
    while (gaps_on && $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.tx_byte  <= tx;
    in_ch.send_ack <= ack_sel;
    in_ch.sda_in   <= sda;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (m_seq == SEQ_IDLE && cmd >= i2cm_pkg::CMD_START && cmd <= i2cm_pkg::CMD_STOP)
      n_cmds++;
    beat = advance_engine(cmd, tx, ack_sel, sda);
    pending_bus_q.push_back(beat);
    n_ticks++;
  endtask

  // issue one command and tick until the engine is idle again; the slave acks
  // after ack_after polls, data bits follow sda_pick
  task automatic run_command(logic [2:0] cmd, logic [7:0] tx, logic ack_sel,
                             int unsigned ack_after, int unsigned sda_pick);
    int unsigned polls;
    logic        sda;
    polls = 0;
    send_tick(cmd, tx, ack_sel, 1'($urandom_range(1)));
    while (m_seq != SEQ_IDLE) begin
      if (m_seq == SEQ_WACK_POLL) begin
        sda = (polls >= ack_after) ? 1'b0 : 1'b1;
        polls++;
      end else if (sda_pick == SDA_RANDOM) begin
        sda = 1'($urandom_range(1));
      end else begin
        sda = (sda_pick == SDA_HIGH);
      end
      // commands arriving mid-transfer must be ignored
      send_tick(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)), sda);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_bus_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [i2cm_pkg::CfgWidth-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk);
    cfg_we_i <= 1'b0;
    @(posedge clk);
    if (idx == i2cm_pkg::CFG_HALF_PERIOD) half_cfg = val;
    else tmo_cfg = val[i2cm_pkg::TmoWidth-1:0];
  endtask

  task automatic test_reset_defaults();
    // reset timing: a start runs at the default half period
    run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, 0, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_NONE, 8'h00, 1'b0, 0, SDA_RANDOM);
  endtask

  task automatic test_directed_bus();
    drain_results();
    write_reg(i2cm_pkg::CFG_HALF_PERIOD, 16'd1);
    write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, 16'd3);
    run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, 0, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1, 0, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_WRITE, 8'h00, 1'b0, 2, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_WRITE, 8'h80, 1'b0, NO_ACK, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_NONE, 8'hFF, 1'b1, 0, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, 0, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_READ, 8'h00, 1'b1, 0, SDA_HIGH);
    run_command(i2cm_pkg::CMD_READ, 8'hFF, 1'b0, 0, SDA_LOW);
    // repeated start straight after a read
    run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, 0, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_WRITE, 8'h3C, 1'b0, 1, SDA_RANDOM);
    run_command(3'd5, 8'hA5, 1'b1, 0, SDA_RANDOM);
    run_command(3'd6, 8'h5A, 1'b0, 0, SDA_RANDOM);
    run_command(3'd7, 8'hFF, 1'b1, 0, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);
  endtask

  task automatic test_zero_settings();
    drain_results();
    write_reg(i2cm_pkg::CFG_HALF_PERIOD, 16'd0);
    write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, 16'd0);
    run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, 0, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_WRITE, 8'h55, 1'b0, 0, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_WRITE, 8'hAA, 1'b1, 5, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_READ, 8'h00, 1'b1, 0, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);
  endtask

  task automatic test_random_traffic();
    int unsigned first_tick;
    int unsigned round_no;
    int unsigned ack_after;
    first_tick = n_ticks;
    round_no = 0;
    while (n_ticks - first_tick < 80) begin
      drain_results();
      write_reg(i2cm_pkg::CFG_HALF_PERIOD,
                (round_no == 0) ? 16'd1 : 16'($urandom_range(1, 2)));
      write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, 16'($urandom_range(1, 8)));
      repeat (2) begin
        run_command(i2cm_pkg::CMD_START, 8'($urandom), 1'($urandom_range(1)), 0,
                    SDA_RANDOM);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(1)) begin
            ack_after = ($urandom_range(4) == 0) ? NO_ACK :
                        $urandom_range((tmo_cfg > 0) ? tmo_cfg - 1 : 0);
            run_command(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom_range(1)),
                        ack_after, SDA_RANDOM);
          end else begin
            run_command(i2cm_pkg::CMD_READ, 8'($urandom), 1'($urandom_range(1)), 0,
                        SDA_RANDOM);
          end
        end
        // broken sequences: stray or unknown commands
        if ($urandom_range(4) == 0)
          run_command(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                      $urandom_range(3), SDA_RANDOM);
        if ($urandom_range(9) != 0)
          run_command(i2cm_pkg::CMD_STOP, 8'($urandom), 1'($urandom_range(1)), 0,
                      SDA_RANDOM);
        repeat ($urandom_range(2))
          run_command(i2cm_pkg::CMD_NONE, 8'($urandom), 1'($urandom_range(1)), 0,
                      SDA_RANDOM);
        if ($urandom_range(3) == 0) drain_results();
      end
      round_no++;
    end
  endtask

  task automatic test_timeout_register();
    drain_results();
    gaps_on = 1'b0;
    write_reg(i2cm_pkg::CFG_HALF_PERIOD, 16'd1);
    // upper data bits are not part of the timeout register
    write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, {8'($urandom_range(1, 255)), 8'd20});
    run_command(i2cm_pkg::CMD_WRITE, 8'h5A, 1'b0, NO_ACK, SDA_RANDOM);
    run_command(i2cm_pkg::CMD_WRITE, 8'hE7, 1'b1, 19, SDA_RANDOM);
    drain_results();
    gaps_on = 1'b1;
    run_command(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      n_mismatch++;
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // result channel: random stalls and scoreboard
  initial begin
    i2cm_pkg::result_t want;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        n_checked++;
        if (pending_bus_q.size() == 0) begin
          n_mismatch++;
          $error("result beat with nothing expected");
        end else begin
          want = pending_bus_q.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(out_ch.scl_level));
          check_field("sda_level", 8'(want.sda_level), 8'(out_ch.sda_level));
          check_field("busy_res", 8'(want.busy_res), 8'(out_ch.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(out_ch.done_res));
          check_field("rx_byte", want.rx_byte, out_ch.rx_byte);
          check_field("ack_error", 8'(want.ack_error), 8'(out_ch.ack_error));
        end
      end
      out_ch.ready <= !gaps_on || ($urandom_range(99) >= 36);
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= i2cm_pkg::CFG_HALF_PERIOD;
    cfg_data_i     <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= i2cm_pkg::CMD_NONE;
    in_ch.tx_byte  <= '0;
    in_ch.send_ack <= 1'b0;
    in_ch.sda_in   <= 1'b1;
    half_cfg     = i2cm_pkg::HALF_PERIOD_RESET;
    tmo_cfg      = i2cm_pkg::ACK_TIMEOUT_RESET;
    m_seq        = SEQ_IDLE;
    m_bit        = '0;
    m_shift      = '0;
    m_delay      = '0;
    m_poll       = '0;
    m_rx         = '0;
    m_scl        = 1'b1;
    m_sda        = 1'b1;
    m_nack       = 1'b0;
    m_ack_choice = 1'b0;
    gaps_on      = 1'b1;
    n_ticks      = 0;
    n_cmds       = 0;
    n_checked    = 0;
    n_mismatch   = 0;
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed_bus();
    test_zero_settings();
    test_random_traffic();
    test_timeout_register();

    drain_results();
    repeat (10) @(posedge clk);
    $display("covered %0d engine ticks with %0d bus commands, half periods 0 to 2 and 50",
             n_ticks, n_cmds);
    $display("%0d result beats compared, ack timeouts 0 to 20, random stalls both sides",
             n_checked);
    if (n_mismatch == 0 && pending_bus_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_if.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_queue.sv
hw/rtl/i2cm_engine.sv
hw/rtl/i2c_master_byte_engine.sv
verif/tb_top.sv
